// ===== design/ifmt_pkg.sv =====
// Shared constants, types and helper functions of the integer field formatter.
`default_nettype none

package ifmt_pkg;

  localparam int VALUE_BITS = 64;
  localparam int MAX_FIELD  = 63;

  localparam int FIELD_W  = 6;
  localparam int LEN_W    = FIELD_W + 1;
  localparam int NDIG     = (VALUE_BITS * 77) / 256 + 1;
  localparam int DIG_BITS = NDIG * 4;
  localparam int CNT_W    = $clog2(NDIG + 1);
  localparam int CONV_W   = $clog2(VALUE_BITS);

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_HEX_A = 8'h61;

  typedef enum logic [4:0] {
    ST_IDLE      = 5'b00001,
    ST_CONVERT   = 5'b00010,
    ST_NORMALISE = 5'b00100,
    ST_LAYOUT    = 5'b01000,
    ST_EMIT      = 5'b10000
  } state_e;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic norm_step;
    logic layout;
    logic emit_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hex;
    logic conv_last;
    logic norm_done;
    logic out_free;
    logic last_char;
  } dp_status_t;

  function automatic logic [7:0] digit_glyph(input logic [3:0] d);
    logic [7:0] g;
    if (d < 4'd10) begin
      g = CHAR_ZERO + {4'd0, d};
    end else begin
      g = CHAR_HEX_A + {4'd0, d - 4'd10};
    end
    return g;
  endfunction

  function automatic logic [FIELD_W-1:0] clamp_field(input logic [FIELD_W-1:0] v);
    logic [FIELD_W-1:0] r;
    if (LEN_W'(v) > LEN_W'(MAX_FIELD)) begin
      r = FIELD_W'(MAX_FIELD);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/integer_field_formatter.sv =====
// Flow: decimal values pass through the bit-serial binary-to-decimal conversion, hex values skip it;
// leading zero digits are then dropped in normalisation, the layout is set, and characters are emitted.
// Throughput: one character per cycle while the output is not stalled; a transaction is held up
// chiefly by the bit-serial binary-to-decimal shifter and the one-character output register.
// A new transaction is taken as soon as the last character has entered the output register.
// Reset is asynchronous and active low; it returns the controller to idle and empties the output.
`default_nettype none

module integer_field_formatter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] value_i,
  input  wire logic        signed_mode_i,
  input  wire logic        hex_mode_i,
  input  wire logic [5:0]  field_width_i,
  input  wire logic        precision_given_i,
  input  wire logic [5:0]  min_digits_i,
  input  wire logic        zero_fill_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_char_o,
  output logic             last_o
);

  ifmt_pkg::ctrl_cmd_t  cmd;
  ifmt_pkg::dp_status_t status;

  ifmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ifmt_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .value_i           (value_i),
    .signed_mode_i     (signed_mode_i),
    .hex_mode_i        (hex_mode_i),
    .field_width_i     (field_width_i),
    .precision_given_i (precision_given_i),
    .min_digits_i      (min_digits_i),
    .zero_fill_i       (zero_fill_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_char_o        (out_char_o),
    .last_o            (last_o)
  );

endmodule

`default_nettype wire

// ===== design/ifmt_ctrl.sv =====
// Controller state machine that sequences conversion, normalisation, layout and emission.
`default_nettype none

module ifmt_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire ifmt_pkg::dp_status_t  status_i,
  output ifmt_pkg::ctrl_cmd_t        cmd_o
);

  ifmt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ifmt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ifmt_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ifmt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ifmt_pkg::ST_CONVERT;
        end
      end
      ifmt_pkg::ST_CONVERT: begin
        if (status_i.hex) begin
          state_d = ifmt_pkg::ST_NORMALISE;
        end else begin
          cmd_o.conv_step = 1'b1;
          if (status_i.conv_last) begin
            state_d = ifmt_pkg::ST_NORMALISE;
          end
        end
      end
      ifmt_pkg::ST_NORMALISE: begin
        if (status_i.norm_done) begin
          state_d = ifmt_pkg::ST_LAYOUT;
        end else begin
          cmd_o.norm_step = 1'b1;
        end
      end
      ifmt_pkg::ST_LAYOUT: begin
        cmd_o.layout = 1'b1;
        state_d      = ifmt_pkg::ST_EMIT;
      end
      ifmt_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit_step = 1'b1;
          if (status_i.last_char) begin
            state_d = ifmt_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ifmt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/ifmt_datapath.sv =====
// Datapath: operand registers, serial binary-to-decimal shifter, digit register and output stage.
`default_nettype none

module ifmt_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ifmt_pkg::ctrl_cmd_t           cmd_i,
  output ifmt_pkg::dp_status_t               status_o,
  input  wire logic [63:0]                   value_i,
  input  wire logic                          signed_mode_i,
  input  wire logic                          hex_mode_i,
  input  wire logic [ifmt_pkg::FIELD_W-1:0]  field_width_i,
  input  wire logic                          precision_given_i,
  input  wire logic [ifmt_pkg::FIELD_W-1:0]  min_digits_i,
  input  wire logic                          zero_fill_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [7:0]                         out_char_o,
  output logic                               last_o
);

  localparam int VB = ifmt_pkg::VALUE_BITS;
  localparam int DW = ifmt_pkg::DIG_BITS;
  localparam int FW = ifmt_pkg::FIELD_W;
  localparam int LW = ifmt_pkg::LEN_W;
  localparam int CW = ifmt_pkg::CNT_W;

  logic [VB-1:0]                mag_q, mag_d;
  logic [DW-1:0]                dig_q, dig_d;
  logic [CW-1:0]                ndig_q, ndig_d;
  logic [ifmt_pkg::CONV_W-1:0]  conv_cnt_q, conv_cnt_d;
  logic                         neg_q, neg_d;
  logic                         hex_q, hex_d;
  logic                         prec_on_q, prec_on_d;
  logic                         zpad_q, zpad_d;
  logic [FW-1:0]                width_q, width_d;
  logic [FW-1:0]                prec_q, prec_d;
  logic [FW-1:0]                pads_q, pads_d;
  logic [FW-1:0]                zeros_q, zeros_d;
  logic                         out_valid_q, out_valid_d;
  logic [7:0]                   out_char_q, out_char_d;
  logic                         last_q, last_d;

  logic [VB-1:0]  raw;
  logic           raw_neg;
  logic [VB-1:0]  raw_mag;
  logic [DW-1:0]  bcd_adj;
  logic [3:0]     top_digit;
  logic           last_char;
  logic [LW-1:0]  ndig_l;
  logic [LW-1:0]  zeros_l;
  logic [LW-1:0]  content_l;
  logic [LW-1:0]  pads_l;

  assign raw       = value_i[VB-1:0];
  assign raw_neg   = signed_mode_i & raw[VB-1];
  assign raw_mag   = raw_neg ? (~raw + VB'(1)) : raw;
  assign top_digit = dig_q[DW-1 -: 4];
  assign last_char = (pads_q == '0) && !neg_q && (zeros_q == '0) && (ndig_q == CW'(1));

  always_comb begin
    for (int i = 0; i < ifmt_pkg::NDIG; i++) begin
      if (dig_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = dig_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = dig_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    ndig_l    = LW'(ndig_q);
    zeros_l   = '0;
    if (prec_on_q && ({1'b0, prec_q} > ndig_l)) begin
      zeros_l = {1'b0, prec_q} - ndig_l;
    end
    content_l = LW'(neg_q) + zeros_l + ndig_l;
    pads_l    = '0;
    if ({1'b0, width_q} > content_l) begin
      pads_l = {1'b0, width_q} - content_l;
    end
    if (zpad_q && !prec_on_q) begin
      zeros_l = zeros_l + pads_l;
      pads_l  = '0;
    end
  end

  always_comb begin
    mag_d       = mag_q;
    dig_d       = dig_q;
    ndig_d      = ndig_q;
    conv_cnt_d  = conv_cnt_q;
    neg_d       = neg_q;
    hex_d       = hex_q;
    prec_on_d   = prec_on_q;
    zpad_d      = zpad_q;
    width_d     = width_q;
    prec_d      = prec_q;
    pads_d      = pads_q;
    zeros_d     = zeros_q;
    out_char_d  = out_char_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (cmd_i.load) begin
      mag_d      = raw_mag;
      dig_d      = hex_mode_i ? DW'(raw_mag) : '0;
      ndig_d     = CW'(ifmt_pkg::NDIG);
      conv_cnt_d = '0;
      neg_d      = raw_neg;
      hex_d      = hex_mode_i;
      prec_on_d  = precision_given_i;
      zpad_d     = zero_fill_i;
      width_d    = ifmt_pkg::clamp_field(field_width_i);
      prec_d     = ifmt_pkg::clamp_field(min_digits_i);
    end else if (cmd_i.conv_step) begin
      dig_d      = {bcd_adj[DW-2:0], mag_q[VB-1]};
      mag_d      = {mag_q[VB-2:0], 1'b0};
      conv_cnt_d = conv_cnt_q + ifmt_pkg::CONV_W'(1);
    end else if (cmd_i.norm_step) begin
      dig_d  = {dig_q[DW-5:0], 4'd0};
      ndig_d = ndig_q - CW'(1);
    end else if (cmd_i.layout) begin
      pads_d  = pads_l[FW-1:0];
      zeros_d = zeros_l[FW-1:0];
    end else if (cmd_i.emit_step) begin
      out_valid_d = 1'b1;
      last_d      = last_char;
      if (pads_q != '0) begin
        out_char_d = ifmt_pkg::CHAR_SPACE;
        pads_d     = pads_q - FW'(1);
      end else if (neg_q) begin
        out_char_d = ifmt_pkg::CHAR_MINUS;
        neg_d      = 1'b0;
      end else if (zeros_q != '0) begin
        out_char_d = ifmt_pkg::CHAR_ZERO;
        zeros_d    = zeros_q - FW'(1);
      end else begin
        out_char_d = ifmt_pkg::digit_glyph(top_digit);
        dig_d      = {dig_q[DW-5:0], 4'd0};
        ndig_d     = ndig_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      conv_cnt_q  <= '0;
      ndig_q      <= '0;
      pads_q      <= '0;
      zeros_q     <= '0;
      neg_q       <= 1'b0;
      hex_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      conv_cnt_q  <= conv_cnt_d;
      ndig_q      <= ndig_d;
      pads_q      <= pads_d;
      zeros_q     <= zeros_d;
      neg_q       <= neg_d;
      hex_q       <= hex_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    dig_q      <= dig_d;
    prec_on_q  <= prec_on_d;
    zpad_q     <= zpad_d;
    width_q    <= width_d;
    prec_q     <= prec_d;
    out_char_q <= out_char_d;
    last_q     <= last_d;
  end

  assign status_o.hex       = hex_q;
  assign status_o.conv_last = (conv_cnt_q == ifmt_pkg::CONV_W'(VB - 1));
  assign status_o.norm_done = (ndig_q == CW'(1)) || (top_digit != 4'd0);
  assign status_o.out_free  = !out_valid_q || !out_stall_i;
  assign status_o.last_char = last_char;

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking testbench of the integer field formatter, with a text predictor and random handshakes.
`timescale 1ns / 100ps

module tb_top;

  typedef struct packed {
    logic [63:0] value;
    logic        signed_mode;
    logic        hex_mode;
    logic [5:0]  field_width;
    logic        precision_given;
    logic [5:0]  min_digits;
    logic        zero_fill;
    logic        drain;
  } fmt_req_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  localparam string GLYPHS = "0123456789abcdef";
  localparam logic [7:0] ASCII_MINUS = 8'h2D;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_SPACE = 8'h20;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        out_stall = 1'b0;
  logic [7:0]  out_char_o;
  logic        last_o;
  fmt_req_t    cur_req = '0;

  fmt_req_t    pending_reqs[$];
  text_char_t  expected_text[$];
  text_char_t  head_char;
  int unsigned accepted_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  logic        quiet_in = 1'b0;
  logic        quiet_out = 1'b0;
  logic        long_hold_done = 1'b0;

  integer_field_formatter u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall_o),
    .value_i           (cur_req.value),
    .signed_mode_i     (cur_req.signed_mode),
    .hex_mode_i        (cur_req.hex_mode),
    .field_width_i     (cur_req.field_width),
    .precision_given_i (cur_req.precision_given),
    .min_digits_i      (cur_req.min_digits),
    .zero_fill_i       (cur_req.zero_fill),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall),
    .out_char_o        (out_char_o),
    .last_o            (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Works out the characters of one formatted field and appends them to the expected text.
  function automatic void predict_text(fmt_req_t r);
    logic [63:0] mag;
    logic [63:0] radix;
    logic        neg;
    logic [7:0]  digits[$];
    logic [7:0]  line[$];
    int          ndig;
    int          zeros;
    int          pads;
    int          content;
    int          fw;
    int          md;
    text_char_t  c;
    neg   = r.signed_mode && r.value[63];
    mag   = neg ? (64'd0 - r.value) : r.value;
    radix = r.hex_mode ? 64'd16 : 64'd10;
    fw    = (r.field_width > ifmt_pkg::MAX_FIELD) ? ifmt_pkg::MAX_FIELD : int'(r.field_width);
    md    = (r.min_digits > ifmt_pkg::MAX_FIELD) ? ifmt_pkg::MAX_FIELD : int'(r.min_digits);
    do begin
      digits.push_front(GLYPHS[int'(mag % radix)]);
      mag = mag / radix;
    end while (mag != 64'd0);
    ndig    = digits.size();
    zeros   = (r.precision_given && md > ndig) ? md - ndig : 0;
    content = (neg ? 1 : 0) + zeros + ndig;
    pads    = (fw > content) ? fw - content : 0;
    if (r.zero_fill && !r.precision_given) begin
      zeros += pads;
      pads = 0;
    end
    repeat (pads) line.push_back(ASCII_SPACE);
    if (neg) line.push_back(ASCII_MINUS);
    repeat (zeros) line.push_back(ASCII_ZERO);
    foreach (digits[i]) line.push_back(digits[i]);
    while (line.size() > 64) void'(line.pop_back());
    foreach (line[i]) begin
      c.ch   = line[i];
      c.last = (i == line.size() - 1);
      expected_text.push_back(c);
    end
  endfunction

  function automatic fmt_req_t make_req(logic [63:0] v, logic sg, logic hx, int fw,
                                         logic pg, int md, logic zp);
    fmt_req_t r;
    r.value           = v;
    r.signed_mode     = sg;
    r.hex_mode        = hx;
    r.field_width     = 6'(fw);
    r.precision_given = pg;
    r.min_digits      = 6'(md);
    r.zero_fill       = zp;
    r.drain           = 1'b0;
    return r;
  endfunction

  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v = v;
      1: v = 64'($urandom_range(0, 999));
      2: v = 64'd0 - 64'($urandom_range(1, 999));
      3: v = v >> $urandom_range(0, 63);
      4: begin
        case ($urandom_range(0, 4))
          0: v = 64'd0;
          1: v = 64'd1;
          2: v = 64'hFFFF_FFFF_FFFF_FFFF;
          3: v = 64'h8000_0000_0000_0000;
          default: v = 64'h7FFF_FFFF_FFFF_FFFF;
        endcase
      end
      default: v = ~(v >> $urandom_range(0, 63));
    endcase
    return v;
  endfunction

  function automatic int pick_field();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 24);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_in || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int unsigned pick_stall();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3) : $urandom_range(8, 40);
  endfunction

  // Input side: a transaction completes when valid is high and stall is low.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!(in_valid && in_stall_o)) begin
      if (in_valid) begin
        predict_text(cur_req);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() != 0 &&
                   !(pending_reqs[0].drain && expected_text.size() != 0)) begin
        cur_req  <= pending_reqs.pop_front();
        in_valid <= 1'b1;
        gap_left <= pick_gap();
        if ($urandom_range(0, 49) == 0) quiet_in <= ~quiet_in;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output side stall, including one long hold-off that lets the block back up.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (accepted_cnt >= 60 && !long_hold_done) begin
        long_hold_done <= 1'b1;
        stall_left     <= 500;
        out_stall      <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if (!quiet_out && $urandom_range(0, 99) < 20) begin
        stall_left <= pick_stall();
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
      if ($urandom_range(0, 299) == 0) quiet_out <= ~quiet_out;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      if (expected_text.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual %h last %b",
                 $time, out_char_o, last_o);
        mismatch_cnt++;
      end else begin
        head_char = expected_text.pop_front();
        if (head_char.ch !== out_char_o) begin
          $display("%0t: out_char mismatch: expected %h, actual %h",
                   $time, head_char.ch, out_char_o);
          mismatch_cnt++;
        end
        if (head_char.last !== last_o) begin
          $display("%0t: last mismatch: expected %b, actual %b",
                   $time, head_char.last, last_o);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    fmt_req_t r;
    pending_reqs.push_back(make_req(64'd0, 1'b0, 1'b0, 0, 1'b0, 0, 1'b0));
    pending_reqs.push_back(make_req(64'd0, 1'b1, 1'b0, 0, 1'b1, 0, 1'b0));
    pending_reqs.push_back(make_req(64'd0, 1'b0, 1'b1, 63, 1'b1, 0, 1'b1));
    pending_reqs.push_back(make_req(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 0, 1'b0, 0, 1'b0));
    pending_reqs.push_back(make_req(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 0, 1'b0, 0, 1'b0));
    pending_reqs.push_back(make_req(64'h8000_0000_0000_0000, 1'b1, 1'b0, 0, 1'b0, 0, 1'b0));
    pending_reqs.push_back(make_req(64'h8000_0000_0000_0000, 1'b1, 1'b1, 0, 1'b0, 0, 1'b0));
    pending_reqs.push_back(make_req(64'h8000_0000_0000_0000, 1'b0, 1'b1, 0, 1'b0, 0, 1'b0));
    pending_reqs.push_back(make_req(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 63, 1'b0, 0, 1'b1));
    pending_reqs.push_back(make_req(64'd0 - 64'd123, 1'b1, 1'b0, 30, 1'b0, 0, 1'b1));
    pending_reqs.push_back(make_req(64'd42, 1'b0, 1'b0, 20, 1'b1, 5, 1'b1));
    pending_reqs.push_back(make_req(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 63, 1'b1, 63, 1'b0));
    pending_reqs.push_back(make_req(64'hABCDEF, 1'b0, 1'b1, 63, 1'b1, 63, 1'b1));
    pending_reqs.push_back(make_req(64'hDEAD_BEEF, 1'b1, 1'b1, 10, 1'b0, 0, 1'b0));
    pending_reqs.push_back(make_req(64'd12345, 1'b0, 1'b0, 3, 1'b0, 0, 1'b1));
    pending_reqs.push_back(make_req(64'h5555_5555_5555_5555, 1'b0, 1'b0, 25, 1'b0, 0, 1'b0));
    pending_reqs.push_back(make_req(64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0, 0, 1'b1, 25, 1'b0));
    pending_reqs.push_back(make_req(64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b1, 40, 1'b0, 0, 1'b1));
    pending_reqs.push_back(make_req(64'd0 - 64'd7, 1'b1, 1'b1, 0, 1'b1, 1, 1'b0));
    pending_reqs.push_back(make_req(64'd99, 1'b1, 1'b0, 63, 1'b0, 63, 1'b0));
    for (int i = 0; i < 360; i++) begin
      r = make_req(pick_value(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   pick_field(), 1'($urandom_range(0, 1)), pick_field(),
                   1'($urandom_range(0, 1)));
      r.drain = (i == 0) || (i == 200) || ($urandom_range(0, 99) < 3);
      pending_reqs.push_back(r);
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid || expected_text.size() != 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    if (mismatch_cnt == 0 && expected_text.size() == 0) begin
      $display("** integer_field_formatter: PASSED **");
    end else begin
      $display("** integer_field_formatter: FAILED **");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("%0t: timeout", $time);
    $display("** integer_field_formatter: FAILED **");
    $finish;
  end

endmodule
